// ===== hw/rtl/dlw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dlw_pkg;

  localparam logic [7:0] ESC_BYTE    = 8'h1B;
  localparam logic [7:0] NL_BYTE     = 8'h0A;
  localparam logic [7:0] SPACE_BYTE  = 8'h20;
  localparam logic [7:0] TILDE_BYTE  = 8'h7E;
  localparam logic [7:0] LBRACK_BYTE = 8'h5B;
  localparam logic [7:0] SEMI_BYTE   = 8'h3B;
  localparam logic [7:0] DIGIT0_BYTE = 8'h30;
  localparam logic [7:0] DIGIT9_BYTE = 8'h39;
  localparam logic [7:0] VIS_MAX     = 8'hFF;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  localparam logic CFG_IDX_COLS  = 1'b0;
  localparam logic CFG_IDX_LIMIT = 1'b1;

  localparam logic [7:0] COLS_RESET  = 8'd79;
  localparam logic [9:0] LIMIT_RESET = 10'd500;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_val;
    logic [9:0] count;
  } item_t;

  // Results caused by one input transfer: optional end of line, then optional item.
  typedef struct packed {
    logic       has_a;
    logic [9:0] cnt_a;
    logic       has_b;
    item_t      b;
  } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dlw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dlw_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     cols,
  input  wire logic [9:0]     lim,
  input  wire logic           accept,
  input  wire logic [7:0]     data_byte,
  input  wire logic           end_of_data,
  output dlw_pkg::entry_t     entry,
  output logic                entry_we
);
  import dlw_pkg::*;

  logic [7:0] vis_r, vis_nxt;
  logic [9:0] bu_r, bu_nxt;
  logic       esc_r, esc_nxt;
  logic       db_r, db_nxt;
  logic       bp_r, bp_nxt;

  logic       is_esc, is_nl, code_set, printable;
  logic       brk_bp, brk_lead;
  logic [7:0] v0, v1, v3;
  logic [9:0] b0, b1, b2;
  logic       esc0, esc1, esc3;
  logic       db0, db1, db2;
  logic       bp3;
  logic [7:0] ob;
  logic [10:0] b2_p1, lim_w;

  always_comb begin
    is_esc    = (data_byte == ESC_BYTE);
    is_nl     = (data_byte == NL_BYTE);
    code_set  = (data_byte == LBRACK_BYTE) || (data_byte == SEMI_BYTE) ||
                ((data_byte >= DIGIT0_BYTE) && (data_byte <= DIGIT9_BYTE));
    printable = data_byte[7] || ((data_byte >= SPACE_BYTE) && (data_byte <= TILDE_BYTE));
    lim_w     = {1'b0, lim};

    // pending break: ESC continues if it fits under the byte limit, newline is swallowed, anything else breaks first
    brk_bp = bp_r && !(is_esc && (({1'b0, bu_r} + 11'd1) < lim_w)) && !is_nl;
    v0   = brk_bp ? 8'd0  : vis_r;
    b0   = brk_bp ? 10'd0 : bu_r;
    esc0 = brk_bp ? 1'b0  : esc_r;
    db0  = brk_bp ? 1'b0  : db_r;

    db1 = (db0 || data_byte[7]) ? !db0 : db0;
    brk_lead = db1 && (b0 != 10'd0) &&
               ((({1'b0, v0} + 9'd1) >= {1'b0, cols}) || (({1'b0, b0} + 11'd2) >= lim_w));
    v1   = brk_lead ? 8'd0  : v0;
    b1   = brk_lead ? 10'd0 : b0;
    esc1 = brk_lead ? 1'b0  : esc0;
    db2  = brk_lead ? 1'b1  : db1;

    b2    = b1 + 10'd1;
    b2_p1 = {1'b0, b2} + 11'd1;

    if (is_esc) begin
      esc3 = 1'b1;
      v3   = v1;
      ob   = data_byte;
    end else if (esc1) begin
      esc3 = code_set;
      v3   = v1;
      ob   = data_byte;
    end else begin
      esc3 = 1'b0;
      v3   = (v1 == VIS_MAX) ? v1 : v1 + 8'd1;
      ob   = printable ? data_byte : SPACE_BYTE;
    end
    bp3 = ((v3 >= cols) || (b2_p1 >= lim_w)) && !(esc3 && (b2_p1 < lim_w));

    entry = '0;
    vis_nxt = vis_r;
    bu_nxt  = bu_r;
    esc_nxt = esc_r;
    db_nxt  = db_r;
    bp_nxt  = bp_r;
    if (end_of_data) begin
      entry.has_a = (bu_r != 10'd0);
      entry.cnt_a = bu_r;
      vis_nxt = '0;
      bu_nxt  = '0;
      esc_nxt = 1'b0;
      db_nxt  = 1'b0;
      bp_nxt  = 1'b0;
    end else begin
      entry.has_a      = brk_bp || brk_lead;
      entry.cnt_a      = bu_r;
      entry.has_b      = 1'b1;
      entry.b.kind     = is_nl ? KIND_EOL : KIND_BYTE;
      entry.b.byte_val = is_nl ? 8'd0 : ob;
      entry.b.count    = is_nl ? b2 : 10'd0;
      if (is_nl) begin
        vis_nxt = '0;
        bu_nxt  = '0;
        esc_nxt = 1'b0;
        db_nxt  = 1'b0;
        bp_nxt  = 1'b0;
      end else begin
        vis_nxt = v3;
        bu_nxt  = b2;
        esc_nxt = esc3;
        db_nxt  = db2;
        bp_nxt  = bp3;
      end
    end
    entry_we = accept && (entry.has_a || entry.has_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r <= '0;
      bu_r  <= '0;
      esc_r <= 1'b0;
      db_r  <= 1'b0;
      bp_r  <= 1'b0;
    end else if (accept) begin
      vis_r <= vis_nxt;
      bu_r  <= bu_nxt;
      esc_r <= esc_nxt;
      db_r  <= db_nxt;
      bp_r  <= bp_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dlw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dlw_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire dlw_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  output dlw_pkg::entry_t      rd_data,
  output logic                 q_full,
  output logic                 q_empty
);
  import dlw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  always_comb begin
    q_full  = (cnt_r == CNT_W'(DEPTH));
    q_empty = (cnt_r == '0);
    do_wr   = wr_en && !q_full;
    do_rd   = rd_en && !q_empty;
    rd_data = slots_r[rp_r];
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dlw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dlw_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dlw_pkg::entry_t head,
  input  wire logic            head_valid,
  output logic                 head_pop,
  input  wire logic            pop,
  output logic                 empty,
  output dlw_pkg::item_t       item
);
  import dlw_pkg::*;

  logic  out_vld_r, out_vld_nxt;
  item_t out_r, out_nxt;
  logic  hold_vld_r, hold_vld_nxt;
  item_t hold_r, hold_nxt;
  logic  out_free;
  item_t a_item;

  always_comb begin
    a_item.kind     = KIND_EOL;
    a_item.byte_val = 8'd0;
    a_item.count    = head.cnt_a;

    out_free     = !out_vld_r || pop;
    head_pop     = out_free && !hold_vld_r && head_valid;
    out_vld_nxt  = out_vld_r && !pop;
    out_nxt      = out_r;
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    if (out_free) begin
      if (hold_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = hold_r;
        hold_vld_nxt = 1'b0;
      end else if (head_valid) begin
        out_vld_nxt = 1'b1;
        if (head.has_a) begin
          out_nxt      = a_item;
          hold_vld_nxt = head.has_b;
          hold_nxt     = head.b;
        end else begin
          out_nxt = head.b;
        end
      end
    end
    empty = !out_vld_r;
    item  = out_r;
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      hold_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ansi_dbcs_line_wrapper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                               Transfer
// input     in_data_byte, in_end_of_data                        push && !full
// result    out_item_kind, out_out_byte, out_line_byte_count    pop && !empty
// config    cfg_index, cfg_data                                 cfg_we
//
// One input byte per cycle while full is low; the front decodes it in the cycle it is taken.
// The result side gives one result per cycle while pop is high: an input that causes a break
// and a byte gives two results, and QUEUE_DEPTH entries between the two sides absorb such
// bursts. A result passes through the queue and then the output register of the back.
// Reset sets columns to 79 and the byte limit to 500.
module ansi_dbcs_line_wrapper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_data,
  output logic            empty,
  input  wire logic       pop,
  output logic            out_item_kind,
  output logic [7:0]      out_out_byte,
  output logic [9:0]      out_line_byte_count,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [9:0] cfg_data
);
  import dlw_pkg::*;

  logic [7:0] cols_r;
  logic [9:0] lim_r;
  logic       accept;
  entry_t     fe_entry;
  logic       fe_we;
  entry_t     q_head;
  logic       q_full, q_empty, q_pop;
  item_t      res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      lim_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_COLS:  cols_r <= cfg_data[7:0];
        CFG_IDX_LIMIT: lim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  dlw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cols        (cols_r),
    .lim         (lim_r),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .end_of_data (in_end_of_data),
    .entry       (fe_entry),
    .entry_we    (fe_we)
  );

  dlw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fe_we),
    .wr_data (fe_entry),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  dlw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_empty),
    .head_pop   (q_pop),
    .pop        (pop),
    .empty      (empty),
    .item       (res)
  );

  assign out_item_kind       = res.kind;
  assign out_out_byte        = res.byte_val;
  assign out_line_byte_count = res.count;

endmodule
`default_nettype wire

// ===== hw/rtl/dlw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dlw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       out_item_kind,
  input wire logic [7:0] out_out_byte,
  input wire logic [9:0] out_line_byte_count
);
  import dlw_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queue not cleared by reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item_kind) && $stable(out_out_byte) &&
                          $stable(out_line_byte_count)))
    else $error("stalled result changed");

  a_byte_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item_kind == KIND_BYTE) |-> (out_line_byte_count == 10'd0))
    else $error("line byte carries a count");

  a_eol_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item_kind == KIND_EOL) |-> (out_out_byte == 8'd0))
    else $error("end of line carries a byte");

endmodule

bind ansi_dbcs_line_wrapper dlw_checker u_dlw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .full                (full),
  .empty               (empty),
  .pop                 (pop),
  .out_item_kind       (out_item_kind),
  .out_out_byte        (out_out_byte),
  .out_line_byte_count (out_line_byte_count)
);
`default_nettype wire

// ===== dv/ansi_dbcs_line_wrapper_test.sv =====
`timescale 1ns / 1ps
module ansi_dbcs_line_wrapper_test;
  import dlw_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       eod;
  } text_in_t;

  class line_cutter;
    int    cols;
    int    lim;
    int    vis;
    int    used;
    bit    esc;
    bit    dbl;
    bit    brk;
    int    errors;
    item_t cut_items[$];

    function new();
      cols = int'(COLS_RESET);
      lim = int'(LIMIT_RESET);
      errors = 0;
      clear_line();
    endfunction

    function void set_reg(logic idx, logic [9:0] val);
      if (idx == CFG_IDX_COLS) cols = int'(val[7:0]);
      else lim = int'(val);
    endfunction

    function void clear_line();
      vis = 0;
      used = 0;
      esc = 0;
      dbl = 0;
      brk = 0;
    endfunction

    function void emit(logic kind, logic [7:0] b, int cnt);
      item_t it;
      it.kind = kind;
      it.byte_val = b;
      it.count = cnt[9:0];
      cut_items.push_back(it);
    endfunction

    function void close_line();
      emit(KIND_EOL, 8'h00, used);
      clear_line();
    endfunction

    function bit code_byte(logic [7:0] c);
      return c == LBRACK_BYTE || c == SEMI_BYTE || (c >= DIGIT0_BYTE && c <= DIGIT9_BYTE);
    endfunction

    function void feed(logic [7:0] c);
      logic [7:0] shown;
      shown = c;
      if (dbl || c[7]) dbl = !dbl;
      // lead byte that does not fit opens the next line
      if (dbl && used > 0 && (vis >= cols - 1 || used >= lim - 2)) begin
        close_line();
        dbl = 1;
      end
      used = (used + 1) % 1024;
      if (c == NL_BYTE) begin
        close_line();
        return;
      end
      if (c == ESC_BYTE) begin
        esc = 1;
      end else if (esc) begin
        if (!code_byte(c)) esc = 0;
      end else begin
        if (!(c[7] || (c >= SPACE_BYTE && c <= TILDE_BYTE))) shown = SPACE_BYTE;
        if (vis < int'(VIS_MAX)) vis++;
      end
      emit(KIND_BYTE, shown, 0);
      if (vis >= cols || used >= lim - 1) begin
        if (!(esc && used < lim - 1)) brk = 1;
      end
    endfunction

    function void take_input(text_in_t t);
      if (t.eod) begin
        if (used > 0) close_line();
        else clear_line();
        return;
      end
      if (brk) begin
        if (t.ch == ESC_BYTE && used < lim - 1) begin
          brk = 0;
          feed(t.ch);
        end else if (t.ch == NL_BYTE) begin
          used = (used + 1) % 1024;
          close_line();
        end else begin
          close_line();
          feed(t.ch);
        end
      end else begin
        feed(t.ch);
      end
    endfunction

    function void compare_out(item_t got);
      item_t want;
      if (cut_items.size() == 0) begin
        $error("unexpected result: item_kind %0d out_byte 0x%02h line_byte_count %0d",
               got.kind, got.byte_val, got.count);
        errors++;
        return;
      end
      want = cut_items.pop_front();
      if (got.kind !== want.kind) begin
        $error("item_kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.byte_val !== want.byte_val) begin
        $error("out_byte: expected 0x%02h, actual 0x%02h", want.byte_val, got.byte_val);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("line_byte_count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_data = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       out_item_kind;
  logic [7:0] out_out_byte;
  logic [9:0] out_line_byte_count;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic [9:0] cfg_data = 10'h000;

  line_cutter cutter;
  text_in_t   stim_q[$];
  item_t      rx_item;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_request = 0;
  int         hold_left = 0;
  int         quiet = 0;

  ansi_dbcs_line_wrapper dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_data_byte       (in_data_byte),
    .in_end_of_data     (in_end_of_data),
    .empty              (empty),
    .pop                (pop),
    .out_item_kind      (out_item_kind),
    .out_out_byte       (out_out_byte),
    .out_line_byte_count(out_line_byte_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void queue_text(logic [7:0] c, logic eod);
    text_in_t t;
    t.ch = c;
    t.eod = eod;
    stim_q.push_back(t);
  endfunction

  function automatic void refill_text();
    int pick;
    int k;
    pick = $urandom_range(99);
    if (pick < 38) begin
      k = $urandom_range(1, 6);
      repeat (k) queue_text(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
    end else if (pick < 53) begin
      queue_text(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
      queue_text(8'($urandom_range(8'h40, 8'hFF)), 1'b0);
    end else if (pick < 65) begin
      queue_text(ESC_BYTE, 1'b0);
      queue_text(LBRACK_BYTE, 1'b0);
      k = $urandom_range(0, 4);
      repeat (k) begin
        if ($urandom_range(3) == 0) queue_text(SEMI_BYTE, 1'b0);
        else queue_text(8'($urandom_range(DIGIT0_BYTE, DIGIT9_BYTE)), 1'b0);
      end
      if ($urandom_range(1) == 0) queue_text(8'h6D, 1'b0);
      else queue_text(8'($urandom_range(8'h40, 8'h7E)), 1'b0);
    end else if (pick < 75) begin
      queue_text(NL_BYTE, 1'b0);
    end else if (pick < 83) begin
      queue_text(8'($urandom_range(255)), 1'b0);
    end else if (pick < 90) begin
      queue_text(8'($urandom_range(8'h1F)), 1'b0);
    end else if (pick < 94) begin
      queue_text(ESC_BYTE, 1'b0);
      queue_text(8'($urandom_range(255)), 1'b0);
    end else if (pick < 97) begin
      // unpaired lead byte
      queue_text(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
    end else begin
      queue_text(8'($urandom_range(255)), 1'b1);
    end
  endfunction

  task automatic send_text(int n);
    text_in_t t;
    int       gap;
    for (int i = 0; i < n; i++) begin
      if (stim_q.size() == 0) refill_text();
      t = stim_q.pop_front();
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      push <= 1'b1;
      in_data_byte <= t.ch;
      in_end_of_data <= t.eod;
      do @(posedge clk); while (!(push && !full));
      cutter.take_input(t);
    end
    push <= 1'b0;
  endtask

  task automatic drain();
    while (cutter.cut_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(logic [9:0] cols_val, logic [9:0] lim_val);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_COLS;
    cfg_data <= cols_val;
    @(posedge clk);
    cutter.set_reg(CFG_IDX_COLS, cols_val);
    cfg_index <= CFG_IDX_LIMIT;
    cfg_data <= lim_val;
    @(posedge clk);
    cutter.set_reg(CFG_IDX_LIMIT, lim_val);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [9:0] cols_val, logic [9:0] lim_val, int send_pct,
                           int recv_pct, bit hold, int n);
    drain();
    set_limits(cols_val, lim_val);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) hold_request = 1;
    send_text(n);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        rx_item.kind = out_item_kind;
        rx_item.byte_val = out_out_byte;
        rx_item.count = out_line_byte_count;
        cutter.compare_out(rx_item);
      end
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet + 1 >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    cutter = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset limits: control bytes, DEL, both ends of the byte range, escapes
    queue_text(8'h00, 1'b0);
    queue_text(8'h7F, 1'b0);
    queue_text(SPACE_BYTE, 1'b0);
    queue_text(8'hFF, 1'b0);
    queue_text(8'h80, 1'b0);
    queue_text(ESC_BYTE, 1'b0);
    queue_text(LBRACK_BYTE, 1'b0);
    queue_text(DIGIT0_BYTE, 1'b0);
    queue_text(DIGIT9_BYTE, 1'b0);
    queue_text(SEMI_BYTE, 1'b0);
    queue_text(8'h6D, 1'b0);
    queue_text(NL_BYTE, 1'b0);
    queue_text(8'hFF, 1'b1);
    send_text(stim_q.size());

    // narrow line: swallowed newline, lead byte wrap, ESC after width break
    queue_text("a", 1'b0);
    queue_text("b", 1'b0);
    queue_text("c", 1'b0);
    queue_text(NL_BYTE, 1'b0);
    queue_text("a", 1'b0);
    queue_text("b", 1'b0);
    queue_text(8'hA4, 1'b0);
    queue_text(8'h40, 1'b0);
    queue_text("e", 1'b0);
    queue_text(ESC_BYTE, 1'b0);
    queue_text(8'h6D, 1'b0);
    queue_text("z", 1'b0);
    queue_text(8'h00, 1'b1);
    run_phase(10'd3, 10'd8, 0, 0, 0, stim_q.size());

    run_phase(10'd2, 10'd4, 0, 0, 0, 150);
    run_phase(10'h3FF, 10'd1023, 49, 0, 0, 200);
    run_phase(10'd20, 10'd30, 0, 49, 0, 200);
    run_phase(10'd79, 10'd500, 29, 29, 0, 300);
    run_phase(10'd8, 10'd12, 0, 0, 1, 150);
    run_phase(10'd255, 10'd4, 29, 29, 0, 150);
    run_phase(10'd2, 10'd1023, 0, 0, 0, 100);
    run_phase(10'h300, 10'd0, 49, 0, 0, 60);
    run_phase(10'd1, 10'd3, 0, 49, 0, 60);
    drain();

    if (cutter.errors == 0 && cutter.cut_items.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
